### hdl/digit_and_led_display_sequencer_macros.svh
// Assertion macros for the digit and LED display sequencer.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef DIGIT_AND_LED_DISPLAY_SEQUENCER_MACROS_SVH
`define DIGIT_AND_LED_DISPLAY_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define DLDS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define DLDS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/dlds_pkg.sv
// Shared types, constants and helper functions for the display sequencer.
// No dependencies; used by dlds_b2bcd and the top level.
`timescale 1ns / 1ps

package dlds_pkg;

   // Field widths
   localparam int OPCODE_W   = 2;
   localparam int VALUE_W    = 32;
   localparam int SEG_W      = 7;
   localparam int LED_W      = 8;
   localparam int TICK_W     = 16;
   localparam int DIGIT_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Sizing
   localparam int MAX_DIGITS = 10;
   localparam int LED_COUNT  = 8;
   localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int LIT_W      = $clog2(LED_COUNT + 1);
   // Non-negative values only: the sign bit is never converted
   localparam int CONV_W     = VALUE_W - 1;
   localparam int SHIFT_W    = $clog2(CONV_W);

   // Register reset values
   localparam logic [TICK_W-1:0] HOLD_RESET = TICK_W'(500);
   localparam logic [TICK_W-1:0] STEP_RESET = TICK_W'(1000);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIGIT_HOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_STEP   = 1'b1;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_NUMBER = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LEDS   = 2'd2;

   // Run modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_DIGITS = 2'd1;
   localparam logic [1:0] MODE_LEDS   = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [SEG_W-1:0] segments;
      logic [LED_W-1:0] leds;
      logic             busy_res;
      logic             status;
   } rsp_type;

   // Converter status toward the sequencer
   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] total;
   } conv_stat_type;

   // Common-cathode segment pattern, bit0 = a; non-decimal codes are blank
   function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = '0;
      endcase
      return s;
   endfunction

   // Low LEDs lit up to the given count
   function automatic logic [LED_W-1:0] led_mask(input logic [LIT_W-1:0] lit);
      logic [LED_W-1:0] m;
      for (int i = 0; i < LED_W; i++) begin
         m[i] = (i < int'(lit));
      end
      return m;
   endfunction

endpackage

### hdl/digit_and_led_display_sequencer.sv
// Display sequencer: a number command runs through a bit-serial binary to
// decimal unit; tick and LED commands, and rejected or ignored commands, give
// their result in the output register on the edge that takes the transfer, so
// the next transfer can follow once that result is taken. A number command
// that is accepted with a non-negative value holds off the input while the
// converter shifts in each value bit and then scans its stored digits to
// find the digit count.
// Depends on dlds_pkg, dlds_b2bcd and digit_and_led_display_sequencer_macros.svh.
`timescale 1ns / 1ps
`include "digit_and_led_display_sequencer_macros.svh"

module digit_and_led_display_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  dlds_pkg::req_type                    req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dlds_pkg::rsp_type                    rsp_data,
   // register writes
   input  logic                                 csr_we,
   input  logic [dlds_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dlds_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic ST_READY = 1'b0;
   localparam logic ST_CONV  = 1'b1;

   logic                               state_ff, state_in;
   logic [1:0]                         mode_ff, mode_in;
   logic [dlds_pkg::DIG_IDX_W-1:0]     pos_ff, pos_in;
   logic [dlds_pkg::LIT_W-1:0]         lit_ff, lit_in;
   logic [dlds_pkg::TICK_W-1:0]        tick_ff, tick_in;
   logic [dlds_pkg::TICK_W-1:0]        hold_ff, step_ff;
   logic                               rsp_valid_ff;
   dlds_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic                               req_accept;
   logic                               conv_start;
   logic                               rsp_load;
   logic                               status;
   logic [dlds_pkg::TICK_W-1:0]        tick_inc, period;
   logic [dlds_pkg::LIT_W-1:0]         lit_dec;
   logic [dlds_pkg::LIT_W-1:0]         led_req;
   dlds_pkg::conv_stat_type            conv_stat;
   logic [dlds_pkg::MAX_DIGITS-1:0][dlds_pkg::DIGIT_W-1:0] digits;

   // Handshake
   assign req_stall  = (state_ff == ST_CONV) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign conv_start = req_accept && (req_data.opcode == dlds_pkg::OP_NUMBER) &&
                       (mode_ff == dlds_pkg::MODE_IDLE) &&
                       !req_data.value[dlds_pkg::VALUE_W-1];
   assign rsp_load   = (req_accept && !conv_start) || conv_stat.done;

   dlds_b2bcd u_b2bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .value  (req_data.value[dlds_pkg::CONV_W-1:0]),
      .stat   (conv_stat),
      .digits (digits)
   );

   // Tick period and LED count clamp
   always_comb begin
      tick_inc = tick_ff + 1'b1;
      if (mode_ff == dlds_pkg::MODE_DIGITS) begin
         period = (hold_ff == '0) ? dlds_pkg::TICK_W'(1) : hold_ff;
      end else begin
         period = (step_ff == '0) ? dlds_pkg::TICK_W'(1) : step_ff;
      end
      lit_dec = (lit_ff != '0) ? lit_ff - 1'b1 : lit_ff;
      if (req_data.value[dlds_pkg::VALUE_W-1]) begin
         led_req = '0;
      end else if ($unsigned(req_data.value) > dlds_pkg::VALUE_W'(dlds_pkg::LED_COUNT)) begin
         led_req = dlds_pkg::LIT_W'(dlds_pkg::LED_COUNT);
      end else begin
         led_req = req_data.value[dlds_pkg::LIT_W-1:0];
      end
   end

   // Next state of the sequence
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      lit_in   = lit_ff;
      tick_in  = tick_ff;
      status   = 1'b0;
      if (state_ff == ST_CONV) begin
         if (conv_stat.done) begin
            state_in = ST_READY;
            mode_in  = dlds_pkg::MODE_DIGITS;
            pos_in   = dlds_pkg::DIG_IDX_W'(conv_stat.total - dlds_pkg::CNT_W'(1));
            tick_in  = '0;
         end
      end else if (req_accept) begin
         case (req_data.opcode)
            dlds_pkg::OP_TICK: begin
               if (mode_ff != dlds_pkg::MODE_IDLE) begin
                  if (tick_inc >= period) begin
                     tick_in = '0;
                     if (mode_ff == dlds_pkg::MODE_DIGITS) begin
                        if (pos_ff == '0) begin
                           mode_in = dlds_pkg::MODE_IDLE;
                        end else begin
                           pos_in = pos_ff - 1'b1;
                        end
                     end else begin
                        lit_in = lit_dec;
                        if (lit_dec == '0) begin
                           mode_in = dlds_pkg::MODE_IDLE;
                        end
                     end
                  end else begin
                     tick_in = tick_inc;
                  end
               end
            end
            dlds_pkg::OP_NUMBER: begin
               if (mode_ff != dlds_pkg::MODE_IDLE) begin
                  status = 1'b1;
               end else if (conv_start) begin
                  state_in = ST_CONV;
               end
            end
            dlds_pkg::OP_LEDS: begin
               if (mode_ff != dlds_pkg::MODE_IDLE) begin
                  status = 1'b1;
               end else if (led_req != '0) begin
                  lit_in  = led_req;
                  tick_in = '0;
                  mode_in = dlds_pkg::MODE_LEDS;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Drive seen after this transfer
   always_comb begin
      rsp_data_in.segments = (mode_in == dlds_pkg::MODE_DIGITS) ?
                             dlds_pkg::seg_code(digits[pos_in]) : '0;
      rsp_data_in.leds     = (mode_in == dlds_pkg::MODE_LEDS) ?
                             dlds_pkg::led_mask(lit_in) : '0;
      rsp_data_in.busy_res = (mode_in != dlds_pkg::MODE_IDLE);
      rsp_data_in.status   = status;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         mode_ff      <= dlds_pkg::MODE_IDLE;
         pos_ff       <= '0;
         lit_ff       <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         lit_ff   <= lit_in;
         tick_ff  <= tick_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= dlds_pkg::HOLD_RESET;
         step_ff <= dlds_pkg::STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dlds_pkg::CSR_DIGIT_HOLD: hold_ff <= csr_wdata;
            dlds_pkg::CSR_LED_STEP:   step_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `DLDS_ASSERT_NEXT(a_conv_entry, conv_start, (state_ff == ST_CONV) && !rsp_valid_ff, "number transfer did not start conversion with a free output")
   `DLDS_ASSERT_NOW(a_done_in_conv, conv_stat.done, state_ff == ST_CONV, "converter finished outside conversion")
   `DLDS_ASSERT_NOW(a_idle_dark, rsp_valid_ff && !rsp_data_ff.busy_res, (rsp_data_ff.segments == '0) && (rsp_data_ff.leds == '0), "drive lit while idle")
   `DLDS_ASSERT_NOW(a_leds_nonzero, mode_ff == dlds_pkg::MODE_LEDS, lit_ff != '0, "LED sequence with no lit LED")

endmodule

### hdl/dlds_b2bcd.sv
// Bit-serial binary to decimal converter (shift and add-3), then a digit scan.
// Depends on dlds_pkg.
`timescale 1ns / 1ps

module dlds_b2bcd (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             start,
   input  logic [dlds_pkg::CONV_W-1:0]                      value,
   output dlds_pkg::conv_stat_type                          stat,
   output logic [dlds_pkg::MAX_DIGITS-1:0][dlds_pkg::DIGIT_W-1:0] digits
);

   localparam logic [1:0] P_IDLE  = 2'd0;
   localparam logic [1:0] P_SHIFT = 2'd1;
   localparam logic [1:0] P_SCAN  = 2'd2;
   localparam logic [1:0] P_DONE  = 2'd3;

   logic [1:0]                           phase_ff, phase_in;
   logic [dlds_pkg::CONV_W-1:0]          bin_ff, bin_in;
   logic [dlds_pkg::MAX_DIGITS-1:0][dlds_pkg::DIGIT_W-1:0] bcd_ff, bcd_in;
   logic [dlds_pkg::MAX_DIGITS-1:0][dlds_pkg::DIGIT_W-1:0] adj, shifted;
   logic [dlds_pkg::SHIFT_W-1:0]         shift_ff, shift_in;
   logic [dlds_pkg::DIG_IDX_W-1:0]       scan_ff, scan_in;
   logic [dlds_pkg::CNT_W-1:0]           total_ff, total_in;
   logic                                 ovf_ff, ovf_in;

   // Add-3 correction on every digit, then one shift step
   always_comb begin
      for (int i = 0; i < dlds_pkg::MAX_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      shifted[0] = {adj[0][2:0], bin_ff[dlds_pkg::CONV_W-1]};
      for (int i = 1; i < dlds_pkg::MAX_DIGITS; i++) begin
         shifted[i] = {adj[i][2:0], adj[i-1][3]};
      end
   end

   // Sequencer
   always_comb begin
      phase_in = phase_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      shift_in = shift_ff;
      scan_in  = scan_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      case (phase_ff)
         P_IDLE: begin
            if (start) begin
               bin_in   = value;
               bcd_in   = '0;
               shift_in = dlds_pkg::SHIFT_W'(dlds_pkg::CONV_W - 1);
               total_in = '0;
               ovf_in   = 1'b0;
               phase_in = P_SHIFT;
            end
         end
         P_SHIFT: begin
            bin_in = {bin_ff[dlds_pkg::CONV_W-2:0], 1'b0};
            bcd_in = shifted;
            // a carry out of the top digit means the value has more digits than kept
            ovf_in = ovf_ff | adj[dlds_pkg::MAX_DIGITS-1][3];
            if (shift_ff == '0) begin
               scan_in  = '0;
               phase_in = P_SCAN;
            end else begin
               shift_in = shift_ff - 1'b1;
            end
         end
         P_SCAN: begin
            // highest nonzero digit sets the count
            if (bcd_ff[scan_ff] != '0) begin
               total_in = dlds_pkg::CNT_W'(scan_ff) + dlds_pkg::CNT_W'(1);
            end
            if (scan_ff == dlds_pkg::DIG_IDX_W'(dlds_pkg::MAX_DIGITS - 1)) begin
               phase_in = P_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         P_DONE: begin
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         shift_ff <= '0;
         scan_ff  <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         scan_ff  <= scan_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   // Zero shows one digit; overflow keeps every stored digit
   always_comb begin
      stat.done = (phase_ff == P_DONE);
      if (ovf_ff) begin
         stat.total = dlds_pkg::CNT_W'(dlds_pkg::MAX_DIGITS);
      end else if (total_ff == '0) begin
         stat.total = dlds_pkg::CNT_W'(1);
      end else begin
         stat.total = total_ff;
      end
   end

   assign digits = bcd_ff;

endmodule
